@@ rtl/core/ffd_pkg.sv @@
// ----------------------------------------------------------------------------
// Flex-fuel decoder package
// Shared widths, limits, register indexes, reset values and divider status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

   // Result field widths and saturation limits
   localparam int FREQ_W   = 18;
   localparam int PCT_W    = 15;
   localparam int FREQ_MAX = 262143;
   localparam int PCT_MAX  = 32767;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_FLEX_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_E0_HZ         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_E100_HZ       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD_US = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD_US = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_US    = 3'd5;

   // Register reset values
   localparam logic [9:0]  E0_HZ_RST         = 10'd40;
   localparam logic [9:0]  E100_HZ_RST       = 10'd160;
   localparam logic [15:0] MIN_PERIOD_US_RST = 16'd2000;
   localparam logic [19:0] MAX_PERIOD_US_RST = 20'd50000;
   localparam logic [23:0] TIMEOUT_US_RST    = 24'd100000;

   // Divider width: periods of interest stay below 2^20 us
   localparam int DEN_W = 20;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } ffd_div_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/ffd_divider.sv @@
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned divide, one quotient bit per cycle, MSB first. The numerator is
// left-aligned by the caller; iters sets how many bits are consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffd_divider
   import ffd_pkg::*;
#(
   parameter int NUM_W = 29,
   parameter int DIV_DEN_W = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [NUM_W-1:0]               num,
   input  wire logic [DIV_DEN_W-1:0]           den,
   input  wire logic [$clog2(NUM_W+1)-1:0]     iters,
   output logic      [NUM_W-1:0]               quotient,
   output ffd_div_stat_type                    stat
);

   localparam int CNT_W = $clog2(NUM_W+1);

   logic [NUM_W-1:0]     num_ff;
   logic [NUM_W-1:0]     quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DIV_DEN_W:0]   rem_try;
   logic                 fits;
   logic [DIV_DEN_W:0]   rem_sub;
   logic [DIV_DEN_W-1:0] rem_in;

   // Trial subtract of one step
   always_comb begin
      rem_try = {rem_ff, num_ff[NUM_W-1]};
      fits    = (rem_try >= {1'b0, den_ff});
      rem_sub = rem_try - {1'b0, den_ff};
      rem_in  = fits ? rem_sub[DIV_DEN_W-1:0] : rem_try[DIV_DEN_W-1:0];
   end

   // Load on start, then shift one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // Flag the cycle after the last quotient bit
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(1));
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= iters;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ rtl/core/flex_fuel_frequency_decoder.sv @@
// ----------------------------------------------------------------------------
// Flex-fuel sensor frequency decoder
// Turns pin samples into a filtered sensor frequency and ethanol percent.
// ----------------------------------------------------------------------------
// Steps: a request is registered and evaluated; a rising edge with a nonzero
//   in-window period adds a frequency division, and an ethanol division
//   follows when ethanol is enabled and the frequency is above e0. Frequency
//   and percent carry FRAC_BITS fraction bits (Q.8 by default).
// Requests: one at a time, taken the cycle after the previous result is
//   registered. A finished result waits in the output register.
// Reset: synchronous; configuration registers return to defaults, frequency and percent
//   to zero, pin history to high.
`timescale 1ns / 1ps
`default_nettype none

module flex_fuel_frequency_decoder
   import ffd_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Sample requests
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_pin_level,
   input  wire logic [31:0]           req_time_us,
   // Results
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [FREQ_W-1:0]          rsp_freq_hz,
   output logic [PCT_W-1:0]           rsp_ethanol_pct,
   // Configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Divider sizing
   localparam int FREQ_IT = 21 + FRAC_BITS;
   localparam int PCT_IT  = 26;
   localparam int DIV_W   = (FREQ_IT > PCT_IT) ? FREQ_IT : PCT_IT;
   localparam int CNT_W   = $clog2(DIV_W+1);
   localparam int FREQ_SH = DIV_W - FREQ_IT;
   localparam int PCT_SH  = DIV_W - PCT_IT;

   localparam logic [DIV_W-1:0] FREQ_NUM = DIV_W'(64'd1000000 << FRAC_BITS);

   // Ethanol arithmetic
   localparam int E0S_W    = 10 + FRAC_BITS;
   localparam int DIFF_W   = (E0S_W > FREQ_W) ? E0S_W : FREQ_W;
   localparam int PCT_FULL = 100 << FRAC_BITS;
   localparam logic [PCT_W-1:0] PCT_LIM =
      PCT_W'((PCT_FULL < PCT_MAX) ? PCT_FULL : PCT_MAX);
   localparam logic [FREQ_W-1:0] ONE_HZ = FREQ_W'(1 << FRAC_BITS);
   localparam logic [FREQ_W-1:0] FREQ_SAT = FREQ_W'(FREQ_MAX);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_FDIV,
      S_FILTER,
      S_PCT,
      S_PMUL,
      S_PDIV,
      S_OUT
   } state_type;

   // Configuration registers
   logic        flex_enable_ff;
   logic [9:0]  e0_hz_ff;
   logic [9:0]  e100_hz_ff;
   logic [15:0] min_period_us_ff;
   logic [19:0] max_period_us_ff;
   logic [23:0] timeout_us_ff;

   // Decoder state
   state_type           state_ff;
   logic                prev_level_ff;
   logic                edge_seen_ff;
   logic [31:0]         edge_time_ff;
   logic [FREQ_W-1:0]   freq_ff;
   logic [PCT_W-1:0]    pct_ff;

   // Working registers
   logic                rise_ff;
   logic [31:0]         time_ff;
   logic [31:0]         period_ff;
   logic [FREQ_W-1:0]   hz_ff;
   logic [FREQ_W-1:0]   diff_ff;
   logic [9:0]          span_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [FREQ_W-1:0]   rsp_freq_hz_ff;
   logic [PCT_W-1:0]    rsp_ethanol_pct_ff;

   // Divider hookup
   logic                div_start;
   logic [DIV_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic [CNT_W-1:0]    div_iters;
   logic [DIV_W-1:0]    div_quo;
   ffd_div_stat_type    div_stat;

   // Combinational helpers
   logic                accept;
   logic                out_free;
   logic                in_window;
   logic                timed_out;
   logic                freq_go;
   logic [DIV_W-1:0]    freq_num;
   logic [24:0]         prod;
   logic [DIV_W-1:0]    pct_num;
   logic [FREQ_W-1:0]   hz_in;
   logic [FREQ_W+2:0]   blend_sum;
   logic [FREQ_W-1:0]   blend_in;
   logic [DIFF_W-1:0]   freq_ext;
   logic [DIFF_W-1:0]   e0_scaled;
   logic [DIFF_W-1:0]   diff_in;
   logic [9:0]          span_in;
   logic [PCT_W-1:0]    pct_in;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Period checks and divider operands
   always_comb begin
      in_window = (period_ff >= {16'd0, min_period_us_ff}) &&
                  (period_ff <= {12'd0, max_period_us_ff});
      timed_out = edge_seen_ff && (period_ff > {8'd0, timeout_us_ff});
      freq_go   = rise_ff && edge_seen_ff && in_window && (period_ff != 32'd0);
      freq_num  = (FREQ_NUM + DIV_W'(period_ff[19:1])) << FREQ_SH;
      prod      = 25'(diff_ff) * 25'd100;
      pct_num   = (DIV_W'(prod) + DIV_W'(span_ff[9:1])) << PCT_SH;

      div_start = 1'b0;
      div_num   = freq_num;
      div_den   = period_ff[DEN_W-1:0];
      div_iters = CNT_W'(FREQ_IT);
      if (state_ff == S_EVAL) begin
         div_start = freq_go;
      end else if (state_ff == S_PMUL) begin
         div_start = 1'b1;
         div_num   = pct_num;
         div_den   = DEN_W'(span_ff);
         div_iters = CNT_W'(PCT_IT);
      end
   end

   // Frequency saturation and 3/4 old + 1/4 new blend
   always_comb begin
      hz_in     = (|div_quo[DIV_W-1:FREQ_W]) ? FREQ_SAT : div_quo[FREQ_W-1:0];
      blend_sum = {1'b0, freq_ff, 2'b00} - {3'b000, freq_ff} +
                  {3'b000, hz_ff} + (FREQ_W+3)'(2);
      blend_in  = (|blend_sum[FREQ_W+2:FREQ_W+2]) ? FREQ_SAT
                                                  : blend_sum[FREQ_W+1:2];
   end

   // Ethanol difference, span and final clamp
   always_comb begin
      freq_ext  = DIFF_W'(freq_ff);
      e0_scaled = DIFF_W'(e0_hz_ff) << FRAC_BITS;
      diff_in   = freq_ext - e0_scaled;
      span_in   = (e100_hz_ff > e0_hz_ff) ? (e100_hz_ff - e0_hz_ff) : 10'd1;
      pct_in    = (div_quo > DIV_W'(PCT_LIM)) ? PCT_LIM : div_quo[PCT_W-1:0];
   end

   ffd_divider #(
      .NUM_W     (DIV_W),
      .DIV_DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .iters    (div_iters),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         flex_enable_ff   <= 1'b0;
         e0_hz_ff         <= E0_HZ_RST;
         e100_hz_ff       <= E100_HZ_RST;
         min_period_us_ff <= MIN_PERIOD_US_RST;
         max_period_us_ff <= MAX_PERIOD_US_RST;
         timeout_us_ff    <= TIMEOUT_US_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FLEX_ENABLE:   flex_enable_ff   <= csr_data[0];
            CSR_E0_HZ:         e0_hz_ff         <= csr_data[9:0];
            CSR_E100_HZ:       e100_hz_ff       <= csr_data[9:0];
            CSR_MIN_PERIOD_US: min_period_us_ff <= csr_data[15:0];
            CSR_MAX_PERIOD_US: max_period_us_ff <= csr_data[19:0];
            CSR_TIMEOUT_US:    timeout_us_ff    <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Sequencer, decoder state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_level_ff <= 1'b1;
         edge_seen_ff  <= 1'b0;
         edge_time_ff  <= '0;
         freq_ff       <= '0;
         pct_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Drop the result once taken, unless the next one replaces it
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rise_ff       <= req_pin_level && !prev_level_ff;
                  prev_level_ff <= req_pin_level;
                  time_ff       <= req_time_us;
                  period_ff     <= req_time_us - edge_time_ff;
                  state_ff      <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (rise_ff) begin
                  edge_time_ff <= time_ff;
                  edge_seen_ff <= 1'b1;
                  if (edge_seen_ff && in_window) begin
                     if (freq_go) begin
                        state_ff <= S_FDIV;
                     end else begin
                        hz_ff    <= FREQ_SAT;
                        state_ff <= S_FILTER;
                     end
                  end else begin
                     state_ff <= S_PCT;
                  end
               end else begin
                  // Clear frequency and edge memory after a long silence
                  if (timed_out) begin
                     freq_ff      <= '0;
                     edge_seen_ff <= 1'b0;
                     edge_time_ff <= '0;
                  end
                  state_ff <= S_PCT;
               end
            end
            S_FDIV: begin
               if (div_stat.done) begin
                  hz_ff    <= hz_in;
                  state_ff <= S_FILTER;
               end
            end
            S_FILTER: begin
               // Seed the filter while it reads below one hertz
               freq_ff  <= (freq_ff < ONE_HZ) ? hz_ff : blend_in;
               state_ff <= S_PCT;
            end
            S_PCT: begin
               if (!flex_enable_ff) begin
                  state_ff <= S_OUT;
               end else if (freq_ext <= e0_scaled) begin
                  pct_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  diff_ff  <= diff_in[FREQ_W-1:0];
                  span_ff  <= span_in;
                  state_ff <= S_PMUL;
               end
            end
            S_PMUL: begin
               state_ff <= S_PDIV;
            end
            S_PDIV: begin
               if (div_stat.done) begin
                  pct_ff   <= pct_in;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_freq_hz_ff     <= freq_ff;
                  rsp_ethanol_pct_ff <= pct_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_freq_hz     = rsp_freq_hz_ff;
   assign rsp_ethanol_pct = rsp_ethanol_pct_ff;

   // Never restart the divider while it is still working
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // Divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_FDIV || state_ff == S_PDIV))
      else $error("divider result with no one waiting");

   // Frequency is nonzero only while an edge is remembered
   assert property (@(posedge clock) disable iff (reset)
      !edge_seen_ff |-> (freq_ff == '0))
      else $error("frequency held without edge memory");

   // Ethanol percent never exceeds full scale
   assert property (@(posedge clock) disable iff (reset)
      pct_ff <= PCT_LIM)
      else $error("ethanol percent above full scale");

endmodule

`default_nettype wire
